FILE: rtl/rak_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rak_pkg;

  localparam int ID_W       = 31;
  localparam int CNT_W      = 7;
  localparam int POS_W      = 10;
  localparam int QRY_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int REC_W      = FRAC_W + 1;
  localparam int HTOT_W     = 23;
  localparam int HOUT_W     = 22;
  localparam int RSUM_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_K        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GT_PER_QUERY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_COUNT  = 2'd2;

  localparam logic ST_OK          = 1'b0;
  localparam logic ST_SHORT_TRUTH = 1'b1;

  localparam logic MODE_TRUTH     = 1'b0;
  localparam logic MODE_RETRIEVED = 1'b1;

  typedef struct packed {
    logic            valid;
    logic            mark;
    logic [ID_W-1:0] id;
  } rak_link_t;

  typedef struct packed {
    logic              status;
    logic [QRY_W-1:0]  query_index;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  unique_truth;
    logic [REC_W-1:0]  recall_fraction;
    logic [HOUT_W-1:0] running_hits;
    logic [RSUM_W-1:0] running_recall_sum;
    logic [QRY_W-1:0]  counted_queries;
    logic              batch_done;
  } rak_res_t;

endpackage

`default_nettype wire

FILE: rtl/rak_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rak_in_if import rak_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [ID_W-1:0] item_id;

  modport source (output valid, output mode, output item_id, input ready);
  modport sink (input valid, input mode, input item_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/rak_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rak_out_if import rak_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [QRY_W-1:0]  query_index;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  unique_truth;
  logic [REC_W-1:0]  recall_fraction;
  logic [HOUT_W-1:0] running_hits;
  logic [RSUM_W-1:0] running_recall_sum;
  logic [QRY_W-1:0]  counted_queries;
  logic              batch_done;

  modport source (
    output valid, output status, output query_index, output hit_count,
    output unique_truth, output recall_fraction, output running_hits,
    output running_recall_sum, output counted_queries, output batch_done,
    input ready
  );
  modport sink (
    input valid, input status, input query_index, input hit_count,
    input unique_truth, input recall_fraction, input running_hits,
    input running_recall_sum, input counted_queries, input batch_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/rak_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rak_cfg_if import rak_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/recall_at_k_counter_unit.sv
// Recall@k counter. Per query, send gt_per_query ground-truth IDs (mode 0) on in_if,
// then top_k retrieved IDs (mode 1). One result item per query leaves on out_if with
// the hit count, unique truth count, Q1.16 recall and the batch running totals.
// Items whose mode does not fit the current phase are dropped without effect.
// cfg_if is always ready; a write to a listed register clears the query and batch.
// Each input item is accepted in S_IDLE; in S_EVAL the row of cells
// compares the ID against all kept truth IDs in parallel and updates the marks.
// After the last retrieved ID, a bit-serial divider computes the recall, and no
// input item is taken until the result is loaded into the output register.
// The output register holds the result while the receiver stalls; new input items
// are accepted meanwhile, and the next result waits until the register is free.
// Reset sets top_k and gt_per_query to 10, query_count to 1 and clears all counts.
`timescale 1ns / 1ps
`default_nettype none

module recall_at_k_counter_unit import rak_pkg::*; #(
  parameter int K_MAX = 64
) (
  input logic      clk,
  input logic      rst_n,
  rak_in_if.sink   in_if,
  rak_out_if.source out_if,
  rak_cfg_if.sink  cfg_if
);

  localparam int KCAP = (K_MAX > ((1 << CNT_W) - 1)) ? ((1 << CNT_W) - 1) : K_MAX;
  localparam logic [CNT_W-1:0] KCAP_V = CNT_W'(KCAP);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic [ID_W-1:0]   key_r;
  logic [CNT_W-1:0]  top_k_r, top_k_nxt;
  logic [POS_W-1:0]  gpq_r, gpq_nxt;
  logic [QRY_W-1:0]  qcnt_r, qcnt_nxt;
  logic [CNT_W-1:0]  uniq_r, uniq_nxt;
  logic [POS_W-1:0]  tpos_r, tpos_nxt;
  logic [CNT_W-1:0]  rpos_r, rpos_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [QRY_W-1:0]  qidx_r, qidx_nxt;
  logic [HTOT_W-1:0] htot_r, htot_nxt, htot_upd;
  logic [RSUM_W-1:0] rtot_r, rtot_nxt, rtot_upd;
  logic [QRY_W-1:0]  nonempty_r, nonempty_nxt, nonempty_upd;
  logic              out_valid_r, out_valid_nxt;
  rak_res_t          out_r, out_nxt;

  logic              in_acc;
  logic              cfg_wr;
  logic              load;
  logic              clear_query;
  logic              cell_clear;
  logic [CNT_W-1:0]  k_eff;
  logic              truth_phase;
  logic              any_hit;
  logic              new_hit;
  logic              do_shift;
  logic              retr;
  logic              final_item;
  logic              err;
  logic              last;
  logic              div_done;
  logic [REC_W-1:0]  div_quot;
  logic [CNT_W-1:0]  div_hits;
  logic [CNT_W-1:0]  div_uniq;
  logic [K_MAX-1:0]  hit_vec;
  logic [K_MAX-1:0]  mark_vec;
  rak_link_t         head;
  rak_link_t         link [K_MAX];

  assign in_acc = in_if.valid && in_if.ready;
  assign cfg_wr = cfg_if.valid && cfg_if.ready &&
                  ((cfg_if.index == CFG_TOP_K) || (cfg_if.index == CFG_GT_PER_QUERY) ||
                   (cfg_if.index == CFG_QUERY_COUNT));

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign k_eff = (top_k_r == '0) ? CNT_W'(1) : ((top_k_r > KCAP_V) ? KCAP_V : top_k_r);
  assign truth_phase = (tpos_r < gpq_r);
  assign err  = (gpq_r < POS_W'(k_eff));
  assign last = (qidx_r == (qcnt_r - QRY_W'(1)));

  assign any_hit = |hit_vec;
  assign new_hit = |(hit_vec & ~mark_vec);

  assign do_shift = (state_r == S_EVAL) && truth_phase && (mode_r == MODE_TRUTH) &&
                    (tpos_r < POS_W'(k_eff)) && !any_hit && (uniq_r < KCAP_V);
  assign retr = (state_r == S_EVAL) && !truth_phase && (mode_r == MODE_RETRIEVED);
  assign final_item = retr && (({1'b0, rpos_r} + (CNT_W + 1)'(1)) >= {1'b0, k_eff});

  assign div_hits = err ? '0 : (hits_r + CNT_W'(new_hit));
  assign div_uniq = err ? '0 : uniq_r;

  assign load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);
  assign cell_clear = clear_query || cfg_wr;

  assign htot_upd = err ? htot_r : (htot_r + HTOT_W'(hits_r));
  assign rtot_upd = err ? rtot_r : (rtot_r + RSUM_W'(div_quot));
  assign nonempty_upd = (err || (uniq_r == '0)) ? nonempty_r : (nonempty_r + QRY_W'(1));

  assign head = '{valid: 1'b1, mark: 1'b0, id: key_r};

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    rak_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (cell_clear),
      .shift    (do_shift),
      .mark_en  (retr),
      .key      (key_r),
      .link_in  ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
      .link_out (link[i]),
      .hit      (hit_vec[i])
    );
    assign mark_vec[i] = link[i].mark;
  end

  rak_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (final_item),
    .dividend (div_hits),
    .divisor  (div_uniq),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    top_k_nxt     = top_k_r;
    gpq_nxt       = gpq_r;
    qcnt_nxt      = qcnt_r;
    uniq_nxt      = uniq_r;
    tpos_nxt      = tpos_r;
    rpos_nxt      = rpos_r;
    hits_nxt      = hits_r;
    qidx_nxt      = qidx_r;
    htot_nxt      = htot_r;
    rtot_nxt      = rtot_r;
    nonempty_nxt  = nonempty_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_nxt       = out_r;
    clear_query   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (truth_phase) begin
          if (mode_r == MODE_TRUTH) begin
            tpos_nxt = tpos_r + POS_W'(1);
          end
          if (do_shift) begin
            uniq_nxt = uniq_r + CNT_W'(1);
          end
        end else if (mode_r == MODE_RETRIEVED) begin
          if (new_hit) begin
            hits_nxt = hits_r + CNT_W'(1);
          end
          rpos_nxt = rpos_r + CNT_W'(1);
          if (final_item) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          out_valid_nxt              = 1'b1;
          out_nxt.status             = err ? ST_SHORT_TRUTH : ST_OK;
          out_nxt.query_index        = qidx_r;
          out_nxt.hit_count          = err ? '0 : hits_r;
          out_nxt.unique_truth       = err ? '0 : uniq_r;
          out_nxt.recall_fraction    = div_quot;
          out_nxt.running_hits       = htot_upd[HOUT_W-1:0];
          out_nxt.running_recall_sum = rtot_upd;
          out_nxt.counted_queries    = nonempty_upd;
          out_nxt.batch_done         = last;
          clear_query                = 1'b1;
          if (last) begin
            qidx_nxt     = '0;
            htot_nxt     = '0;
            rtot_nxt     = '0;
            nonempty_nxt = '0;
          end else begin
            qidx_nxt     = qidx_r + QRY_W'(1);
            htot_nxt     = htot_upd;
            rtot_nxt     = rtot_upd;
            nonempty_nxt = nonempty_upd;
          end
          state_nxt = S_IDLE;
        end
      end
    endcase

    if (clear_query) begin
      uniq_nxt = '0;
      tpos_nxt = '0;
      rpos_nxt = '0;
      hits_nxt = '0;
    end

    if (cfg_wr) begin
      unique case (cfg_if.index)
        CFG_TOP_K:        top_k_nxt = cfg_if.data[CNT_W-1:0];
        CFG_GT_PER_QUERY: gpq_nxt   = cfg_if.data[POS_W-1:0];
        default:          qcnt_nxt  = cfg_if.data[QRY_W-1:0];
      endcase
      uniq_nxt     = '0;
      tpos_nxt     = '0;
      rpos_nxt     = '0;
      hits_nxt     = '0;
      qidx_nxt     = '0;
      htot_nxt     = '0;
      rtot_nxt     = '0;
      nonempty_nxt = '0;
      state_nxt    = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_k_r     <= CNT_W'(10);
      gpq_r       <= POS_W'(10);
      qcnt_r      <= QRY_W'(1);
      uniq_r      <= '0;
      tpos_r      <= '0;
      rpos_r      <= '0;
      hits_r      <= '0;
      qidx_r      <= '0;
      htot_r      <= '0;
      rtot_r      <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_k_r     <= top_k_nxt;
      gpq_r       <= gpq_nxt;
      qcnt_r      <= qcnt_nxt;
      uniq_r      <= uniq_nxt;
      tpos_r      <= tpos_nxt;
      rpos_r      <= rpos_nxt;
      hits_r      <= hits_nxt;
      qidx_r      <= qidx_nxt;
      htot_r      <= htot_nxt;
      rtot_r      <= rtot_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_if.mode;
      key_r  <= in_if.item_id;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.status             = out_r.status;
  assign out_if.query_index        = out_r.query_index;
  assign out_if.hit_count          = out_r.hit_count;
  assign out_if.unique_truth       = out_r.unique_truth;
  assign out_if.recall_fraction    = out_r.recall_fraction;
  assign out_if.running_hits       = out_r.running_hits;
  assign out_if.running_recall_sum = out_r.running_recall_sum;
  assign out_if.counted_queries    = out_r.counted_queries;
  assign out_if.batch_done         = out_r.batch_done;

  a_uniq_le_k: assert property (@(posedge clk) disable iff (!rst_n)
    uniq_r <= k_eff)
    else $error("Kept truth count exceeds the effective k.");

  a_hits_le_uniq: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= uniq_r)
    else $error("Hit count exceeds the kept truth count.");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("Result item appeared without a load from the output state.");

  a_batch_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last) |=> (qidx_r == '0) && (htot_r == '0) && (rtot_r == '0))
    else $error("Batch totals not cleared after the last query.");

endmodule

`default_nettype wire

FILE: rtl/rak_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rak_cell import rak_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  logic            shift,
  input  logic            mark_en,
  input  logic [ID_W-1:0] key,
  input  rak_link_t       link_in,
  output rak_link_t       link_out,
  output logic            hit
);

  logic            valid_r;
  logic            valid_nxt;
  logic            mark_r;
  logic            mark_nxt;
  logic [ID_W-1:0] id_r;

  assign hit = valid_r && (id_r == key);

  always_comb begin
    valid_nxt = valid_r;
    mark_nxt  = mark_r;
    if (clear) begin
      valid_nxt = 1'b0;
      mark_nxt  = 1'b0;
    end else if (shift) begin
      valid_nxt = link_in.valid;
      mark_nxt  = link_in.mark;
    end else if (mark_en && hit) begin
      mark_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id_r <= link_in.id;
    end
  end

  assign link_out = '{valid: valid_r, mark: mark_r, id: id_r};

endmodule

`default_nettype wire

FILE: rtl/rak_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rak_div import rak_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [REC_W-1:0] quotient
);

  localparam int STEP_W = $clog2(FRAC_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [REC_W-1:0]  quot_r;
  logic [CNT_W:0]    rem2;
  logic              take;
  logic              whole;

  // The dividend never exceeds the divisor, so the integer bit is set only on equality.
  assign whole = (divisor != '0) && (dividend == divisor);
  assign rem2  = {rem_r, 1'b0};
  assign take  = (dvs_r != '0) && (rem2 >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRAC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r  <= divisor;
      rem_r  <= (whole || (divisor == '0)) ? '0 : dividend;
      quot_r <= {whole, {FRAC_W{1'b0}}};
    end else if (busy_r) begin
      rem_r  <= take ? CNT_W'(rem2 - {1'b0, dvs_r}) : rem2[CNT_W-1:0];
      quot_r <= {quot_r[FRAC_W], quot_r[FRAC_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire
